// File: rtl/core/pfe_pkg.sv
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared types, character codes, status codes and the sequencer's microcode
// program for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int DATA_W          = 32;
  localparam int BAL_W           = 17;
  localparam int SYM_W           = 8;
  localparam int STACK_DEPTH_DEF = 32;

  // ASCII codes the block reacts to.
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNBAL = 3'd1,
    ST_UNDER = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_OVER  = 3'd4
  } status_e;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_e                  status;
  } out_beat_t;

  // Divider handshake between the sequencer and the division unit.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

  // Microcode: how the step counter moves on.
  typedef enum logic [3:0] {
    SQ_NEXT     = 4'd0,
    SQ_JUMP     = 4'd1,
    SQ_WAIT_IN  = 4'd2,
    SQ_DISPATCH = 4'd3,
    SQ_UNDER    = 4'd4,
    SQ_OPSEL    = 4'd5,
    SQ_ZERO     = 4'd6,
    SQ_WAIT_DIV = 4'd7,
    SQ_LAST     = 4'd8,
    SQ_WAIT_OUT = 4'd9
  } seq_e;

  // Microcode: what the datapath does in the step.
  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_LATCH     = 4'd1,
    ACT_PUSH      = 4'd2,
    ACT_OPCHK     = 4'd3,
    ACT_RD_SECOND = 4'd4,
    ACT_CAP_B     = 4'd5,
    ACT_ALU_WB    = 4'd6,
    ACT_DIV_GO    = 4'd7,
    ACT_DIV_WB    = 4'd8,
    ACT_RD_FINAL  = 4'd9,
    ACT_EMIT      = 4'd10
  } act_e;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
  localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
  localparam logic [PC_W-1:0] PC_PUSH     = 4'd2;
  localparam logic [PC_W-1:0] PC_OPCHK    = 4'd3;
  localparam logic [PC_W-1:0] PC_RDA      = 4'd4;
  localparam logic [PC_W-1:0] PC_RDB      = 4'd5;
  localparam logic [PC_W-1:0] PC_ALU      = 4'd6;
  localparam logic [PC_W-1:0] PC_DIV_GO   = 4'd7;
  localparam logic [PC_W-1:0] PC_DIV_WAIT = 4'd8;
  localparam logic [PC_W-1:0] PC_END      = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd10;

  typedef struct packed {
    seq_e            seq;
    act_e            act;
    logic [PC_W-1:0] target;
  } ucode_t;

  // The program. Unused addresses fall back to the fetch step.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uc;
    unique case (pc)
      PC_FETCH:    uc = '{seq: SQ_WAIT_IN,  act: ACT_LATCH,     target: PC_DISPATCH};
      PC_DISPATCH: uc = '{seq: SQ_DISPATCH, act: ACT_NONE,      target: PC_END};
      PC_PUSH:     uc = '{seq: SQ_JUMP,     act: ACT_PUSH,      target: PC_END};
      PC_OPCHK:    uc = '{seq: SQ_UNDER,    act: ACT_OPCHK,     target: PC_END};
      PC_RDA:      uc = '{seq: SQ_NEXT,     act: ACT_RD_SECOND, target: PC_RDB};
      PC_RDB:      uc = '{seq: SQ_OPSEL,    act: ACT_CAP_B,     target: PC_DIV_GO};
      PC_ALU:      uc = '{seq: SQ_JUMP,     act: ACT_ALU_WB,    target: PC_END};
      PC_DIV_GO:   uc = '{seq: SQ_ZERO,     act: ACT_DIV_GO,    target: PC_END};
      PC_DIV_WAIT: uc = '{seq: SQ_WAIT_DIV, act: ACT_DIV_WB,    target: PC_END};
      PC_END:      uc = '{seq: SQ_LAST,     act: ACT_RD_FINAL,  target: PC_FETCH};
      PC_EMIT:     uc = '{seq: SQ_WAIT_OUT, act: ACT_EMIT,      target: PC_FETCH};
      default:     uc = '{seq: SQ_JUMP,     act: ACT_NONE,      target: PC_FETCH};
    endcase
    return uc;
  endfunction

  function automatic logic sym_is_digit(input logic [SYM_W-1:0] sym);
    return (sym >= CH_ZERO) && (sym <= CH_NINE);
  endfunction

  function automatic logic sym_is_op(input logic [SYM_W-1:0] sym);
    return (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_MUL) || (sym == CH_DIV);
  endfunction

endpackage

// File: rtl/core/pfe_div.sv
// ----------------------------------------------------------------------------
// Postfix evaluator divider
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating
// toward zero. The quotient wraps for the most negative value by minus one.
// ----------------------------------------------------------------------------
module pfe_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfe_pkg::div_req_t req_i,
  output pfe_pkg::div_rsp_t rsp_o
);
  import pfe_pkg::*;

  localparam int ITER_W = $clog2(DATA_W);

  typedef enum logic [2:0] {
    DS_IDLE = 3'b001,
    DS_RUN  = 3'b010,
    DS_DONE = 3'b100
  } div_state_e;

  div_state_e        state_q, state_d;
  logic [ITER_W-1:0] iter_q;
  logic [DATA_W:0]   rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] dvs_q;
  logic              neg_q;

  logic [DATA_W-1:0] dvd_abs;
  logic [DATA_W-1:0] dvs_abs;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  assign dvd_abs = req_i.dividend[DATA_W-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
  assign dvs_abs = req_i.divisor[DATA_W-1]  ? (~req_i.divisor + 1'b1)  : req_i.divisor;
  assign rem_sh  = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
  assign diff    = rem_sh - {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DS_IDLE: if (req_i.start) state_d = DS_RUN;
      DS_RUN:  if (iter_q == '0) state_d = DS_DONE;
      DS_DONE: state_d = DS_IDLE;
      default: state_d = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DS_IDLE && req_i.start) begin
      rem_q  <= '0;
      quo_q  <= dvd_abs;
      dvs_q  <= dvs_abs;
      neg_q  <= req_i.dividend[DATA_W-1] ^ req_i.divisor[DATA_W-1];
      iter_q <= ITER_W'(DATA_W - 1);
    end else if (state_q == DS_RUN) begin
      iter_q <= iter_q - 1'b1;
      if (!diff[DATA_W]) begin
        rem_q <= diff;
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = (state_q == DS_DONE);
  assign rsp_o.quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// File: rtl/core/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a postfix expression one ASCII character per input beat on a
// signed 32-bit operand stack and returns the top of stack with a status.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload     Handshake
//   -------  ---------  ----------  -------------------------------------
//   in       sink       in_beat_t   in_valid_i / in_stall_o
//   out      source     out_beat_t  out_valid_o / out_stall_i
//
// A digit goes through fetch, dispatch, push and end check, and an ignored
// code goes from dispatch straight to the end check. An operator that finds
// fewer than two operands goes from its check to the end check, and + - or *
// read the two operands one after the other, since the stack memory has a
// single read port.
// A division holds the sequencer while the bit-serial divider runs; a
// division by zero skips the divider.
// The last character of an expression adds one emit step; that step waits
// only while the output register still holds an untaken result.
// Reset clears the step counter, stack count, balance, error and output
// valid; stack entries need no reset since only written entries are read.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pfe_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pfe_pkg::out_beat_t out_data_o
);
  import pfe_pkg::*;

  // Address width of the stack and width of the count, which must hold the
  // full depth itself.
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Sequencer.
  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uc;
  logic            step_go;
  logic            in_acc;
  logic            out_busy;

  // Architectural state.
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [BAL_W-1:0] bal_q, bal_d;
  status_e          err_q, err_d;
  logic [SYM_W-1:0] sym_q;
  logic             last_q;
  logic [DATA_W-1:0] a_q, b_q;

  // Stack memory with one write and one registered read port.
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;

  logic [AW-1:0]     addr_top, addr_second;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0] alu_res;
  logic              cnt_lt2;
  logic              stack_full;

  // Result register.
  logic      out_valid_q;
  out_beat_t out_data_q;
  out_beat_t emit_beat;
  logic      emit_fire;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign uc       = ucode_rom(pc_q);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_busy = out_valid_q && out_stall_i;

  // Only the fetch step takes a beat; everything else is internal work.
  assign in_stall_o = (uc.seq != SQ_WAIT_IN);

  // A waiting step performs its action only in the cycle that it leaves.
  always_comb begin
    case (uc.seq)
      SQ_WAIT_IN:  step_go = in_acc;
      SQ_WAIT_DIV: step_go = div_rsp.done;
      SQ_WAIT_OUT: step_go = !out_busy;
      default:     step_go = 1'b1;
    endcase
  end

  assign cnt_lt2     = (cnt_q < CW'(2));
  assign stack_full  = (cnt_q == CW'(STACK_DEPTH));
  assign addr_top    = AW'(cnt_q - CW'(1));
  assign addr_second = AW'(cnt_q - CW'(2));

  // Next step: sequential, jump, a jump taken on a condition, or a hold while a waiting step waits.
  always_comb begin
    pc_d = pc_q + 1'b1;
    unique case (uc.seq)
      SQ_NEXT:     pc_d = pc_q + 1'b1;
      SQ_JUMP:     pc_d = uc.target;
      SQ_WAIT_IN:  pc_d = in_acc ? uc.target : pc_q;
      SQ_DISPATCH: begin
        if (sym_is_digit(sym_q)) begin
          pc_d = PC_PUSH;
        end else if (sym_is_op(sym_q)) begin
          pc_d = PC_OPCHK;
        end else begin
          pc_d = uc.target;
        end
      end
      SQ_UNDER:    pc_d = cnt_lt2 ? uc.target : pc_q + 1'b1;
      SQ_OPSEL:    pc_d = (sym_q == CH_DIV) ? uc.target : pc_q + 1'b1;
      SQ_ZERO:     pc_d = (a_q == '0) ? uc.target : pc_q + 1'b1;
      SQ_WAIT_DIV: pc_d = div_rsp.done ? uc.target : pc_q;
      SQ_LAST:     pc_d = last_q ? pc_q + 1'b1 : uc.target;
      SQ_WAIT_OUT: pc_d = out_busy ? pc_q : uc.target;
      default:     pc_d = PC_FETCH;
    endcase
  end

  // Plus, minus and multiply all take B as the left operand. The product
  // keeps its low word, which is the wrapped 32-bit result.
  assign prod = b_q * a_q;
  always_comb begin
    case (sym_q)
      CH_PLUS:  alu_res = b_q + a_q;
      CH_MINUS: alu_res = b_q - a_q;
      default:  alu_res = prod[DATA_W-1:0];
    endcase
  end

  // The end-of-expression verdict. A wrong balance overrides any other
  // error; otherwise the first error recorded wins.
  always_comb begin
    emit_beat.value = '0;
    if (bal_q != BAL_W'(1)) begin
      emit_beat.status = ST_UNBAL;
    end else if (err_q != ST_OK) begin
      emit_beat.status = err_q;
    end else if (cnt_q == '0) begin
      emit_beat.status = ST_UNDER;
    end else begin
      emit_beat.status = ST_OK;
      emit_beat.value  = rd_data_q;
    end
  end

  // Datapath control decoded from the action field of the control word.
  always_comb begin
    cnt_d     = cnt_q;
    bal_d     = bal_q;
    err_d     = err_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = addr_second;
    mem_raddr = addr_top;
    mem_wdata = alu_res;
    emit_fire = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = b_q;
    div_req.divisor  = a_q;
    if (step_go) begin
      unique case (uc.act) inside
        ACT_NONE, ACT_CAP_B: begin
        end
        ACT_LATCH: begin
          if (sym_is_digit(in_data_i.symbol)) begin
            bal_d = bal_q + 1'b1;
          end else if (sym_is_op(in_data_i.symbol)) begin
            bal_d = bal_q - 1'b1;
          end
        end
        ACT_PUSH: begin
          if (stack_full) begin
            if (err_q == ST_OK) err_d = ST_OVER;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cnt_q);
            mem_wdata = DATA_W'(sym_q - CH_ZERO);
            cnt_d     = cnt_q + 1'b1;
          end
        end
        ACT_OPCHK: begin
          if (cnt_lt2) begin
            if (err_q == ST_OK) err_d = ST_UNDER;
          end else begin
            mem_re = 1'b1;
          end
        end
        ACT_RD_SECOND: begin
          mem_re    = 1'b1;
          mem_raddr = addr_second;
        end
        ACT_ALU_WB: begin
          mem_we = 1'b1;
          cnt_d  = cnt_q - 1'b1;
        end
        ACT_DIV_GO: begin
          if (a_q == '0) begin
            if (err_q == ST_OK) err_d = ST_DIVZ;
            mem_we    = 1'b1;
            mem_wdata = '0;
            cnt_d     = cnt_q - 1'b1;
          end else begin
            div_req.start = 1'b1;
          end
        end
        ACT_DIV_WB: begin
          mem_we    = 1'b1;
          mem_wdata = div_rsp.quotient;
          cnt_d     = cnt_q - 1'b1;
        end
        ACT_RD_FINAL: begin
          mem_re = last_q && (cnt_q != '0);
        end
        ACT_EMIT: begin
          emit_fire = 1'b1;
          cnt_d     = '0;
          bal_d     = '0;
          err_d     = ST_OK;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_FETCH;
      cnt_q       <= '0;
      bal_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
      bal_q <= bal_d;
      err_q <= err_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: the fetched beat, the two operands and the result.
  always_ff @(posedge clk_i) begin
    if (uc.act == ACT_LATCH && step_go) begin
      sym_q  <= in_data_i.symbol;
      last_q <= in_data_i.last;
    end
    if (uc.act == ACT_RD_SECOND) begin
      a_q <= rd_data_q;
    end
    if (uc.act == ACT_CAP_B) begin
      b_q <= rd_data_q;
    end
    if (emit_fire) begin
      out_data_q <= emit_beat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= stack_mem[mem_raddr];
    end
  end

  pfe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // The stack count never goes past the depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  // A result only appears after the emit step.
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pc_q) == PC_EMIT)
    else $error("result raised outside the emit step");

  // Emitting a result leaves the block clean for the next expression.
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire) |=> (cnt_q == '0 && bal_q == '0 && err_q == ST_OK))
    else $error("state not cleared after a result");

  // The divider only finishes while the sequencer waits for it.
  a_div_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> pc_q == PC_DIV_WAIT)
    else $error("divider done outside the wait step");

  // A good status is only reported for a balanced expression.
  a_ok_bal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && emit_beat.status == ST_OK) |-> bal_q == BAL_W'(1))
    else $error("good status on an unbalanced expression");
`endif

endmodule
